// ===== hdl/dct_pkg.sv =====
`timescale 1ns / 1ps

package dct_pkg;

    // Command codes carried by an input request.
    typedef enum logic [2:0] {
        CMD_RETIRE     = 3'd0,
        CMD_WR_SLOW    = 3'd1,
        CMD_WR_SLOW_CT = 3'd2,
        CMD_WR_FAST    = 3'd3,
        CMD_WR_FAST_CT = 3'd4
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic {
        CFG_INSTR_PER_FAST = 1'b0,
        CFG_FAST_PER_SLOW  = 1'b1
    } t_cfg_idx;

    localparam int CMD_W       = 3;
    localparam int DATA_W      = 32;
    localparam int CTRL_W      = 4;
    localparam int SLOW_W      = 4;
    localparam int IPFT_W      = 10;
    localparam int FPST_W      = 16;
    localparam int CFG_DATA_W  = 16;

    localparam logic [IPFT_W-1:0] IPFT_RESET = 10'd10;
    localparam logic [FPST_W-1:0] FPST_RESET = 16'(8192 / 16);

    // Control bit positions.
    localparam int CTL_RUN  = 0;
    localparam int CTL_INT  = 1;
    localparam int CTL_WAKE = 2;
    localparam int CTL_SREQ = 3;

    // Everything a result carries except the fast counter value.
    typedef struct packed {
        logic              wake;
        logic              irq;
        logic [SLOW_W-1:0] slow_value;
        logic [CTRL_W-1:0] slow_ctrl;
        logic [CTRL_W-1:0] fast_ctrl;
    } t_result;

endpackage

// ===== hdl/dual_countdown_timer_prescaled.sv =====
`timescale 1ns / 1ps

// Two countdown timers clocked by retired-instruction requests. A prescaler
// turns every instructions_per_fast_tick retirements into a fast tick that
// decrements the fast counter while its run bit is set; a second prescaler
// turns every fast_ticks_per_slow_tick fast ticks into a slow decrement.
// A wrap to all ones sets the service-request bit and pulses wake or irq as
// enabled. The block accepts one request per cycle while the output is not
// stalled, and returns one result per request via one input register, then
// the timer state update and a result register. The loop through the phase
// and counter registers sets that rate.
module dual_countdown_timer_prescaled
    import dct_pkg::*;
#(
    parameter int FAST_COUNT_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [CMD_W-1:0]            i_cmd,
    input  logic [DATA_W-1:0]           i_write_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_wake_pulse,
    output logic                        o_irq_pulse,
    output logic [SLOW_W-1:0]           o_slow_value,
    output logic [CTRL_W-1:0]           o_slow_control,
    output logic [FAST_COUNT_WIDTH-1:0] o_fast_value,
    output logic [CTRL_W-1:0]           o_fast_control
);

    logic [IPFT_W-1:0]           r_ipft;
    logic [FPST_W-1:0]           r_fpst;
    logic                        r_s1_valid;
    logic [CMD_W-1:0]            r_s1_cmd;
    logic [DATA_W-1:0]           r_s1_data;
    logic                        r_out_valid;
    t_result                     r_result;
    logic [FAST_COUNT_WIDTH-1:0] r_fast_value;

    t_result                     core_result;
    logic [FAST_COUNT_WIDTH-1:0] core_fast_value;
    logic                        s1_move;
    logic                        in_fire;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipft <= IPFT_RESET;
            r_fpst <= FPST_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INSTR_PER_FAST: r_ipft <= i_cfg_data[IPFT_W-1:0];
                CFG_FAST_PER_SLOW:  r_fpst <= i_cfg_data[FPST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cmd  <= i_cmd;
            r_s1_data <= i_write_data;
        end
    end

    dct_core #(
        .FAST_COUNT_WIDTH(FAST_COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (s1_move),
        .i_cmd        (r_s1_cmd),
        .i_data       (r_s1_data),
        .i_ipft       (r_ipft),
        .i_fpst       (r_fpst),
        .o_result     (core_result),
        .o_fast_value (core_fast_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_result     <= core_result;
            r_fast_value <= core_fast_value;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_wake_pulse   = r_result.wake;
    assign o_irq_pulse    = r_result.irq;
    assign o_slow_value   = r_result.slow_value;
    assign o_slow_control = r_result.slow_ctrl;
    assign o_fast_value   = r_fast_value;
    assign o_fast_control = r_result.fast_ctrl;

endmodule

// ===== hdl/dct_core.sv =====
`timescale 1ns / 1ps

module dct_core
    import dct_pkg::*;
#(
    parameter int FAST_COUNT_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [CMD_W-1:0]            i_cmd,
    input  logic [DATA_W-1:0]           i_data,
    input  logic [IPFT_W-1:0]           i_ipft,
    input  logic [FPST_W-1:0]           i_fpst,
    output t_result                     o_result,
    output logic [FAST_COUNT_WIDTH-1:0] o_fast_value
);

    logic [IPFT_W-1:0]           r_instr_phase, n_instr_phase;
    logic [FPST_W-1:0]           r_slow_phase, n_slow_phase;
    logic [SLOW_W-1:0]           r_slow_counter, n_slow_counter;
    logic [FAST_COUNT_WIDTH-1:0] r_fast_counter, n_fast_counter;
    logic [CTRL_W-1:0]           r_slow_ctrl, n_slow_ctrl;
    logic [CTRL_W-1:0]           r_fast_ctrl, n_fast_ctrl;

    logic fast_tick;
    logic slow_tick;
    logic wake;
    logic irq;

    // A prescale of zero behaves like one since phase+1 >= 0 always holds.
    assign fast_tick = (i_cmd == CMD_RETIRE) &&
                       (({1'b0, r_instr_phase} + 11'd1) >= {1'b0, i_ipft});
    assign slow_tick = fast_tick &&
                       (({1'b0, r_slow_phase} + 17'd1) >= {1'b0, i_fpst});

    always_comb begin
        n_instr_phase  = r_instr_phase;
        n_slow_phase   = r_slow_phase;
        n_slow_counter = r_slow_counter;
        n_fast_counter = r_fast_counter;
        n_slow_ctrl    = r_slow_ctrl;
        n_fast_ctrl    = r_fast_ctrl;
        wake           = 1'b0;
        irq            = 1'b0;
        case (i_cmd)
            CMD_RETIRE: begin
                if (fast_tick) begin
                    n_instr_phase = '0;
                    if (r_fast_ctrl[CTL_RUN]) begin
                        n_fast_counter = r_fast_counter -
                                         {{(FAST_COUNT_WIDTH-1){1'b0}}, 1'b1};
                        // Wrapping from zero to all ones raises the service request.
                        if (r_fast_counter == '0) begin
                            n_fast_ctrl[CTL_SREQ] = 1'b1;
                            wake = wake | r_fast_ctrl[CTL_WAKE];
                            irq  = irq | r_fast_ctrl[CTL_INT];
                        end
                    end
                    if (slow_tick) begin
                        n_slow_phase   = '0;
                        n_slow_counter = r_slow_counter - 4'd1;
                        if (r_slow_counter == '0) begin
                            n_slow_ctrl[CTL_SREQ] = 1'b1;
                            wake = wake | r_slow_ctrl[CTL_WAKE];
                            irq  = irq | r_slow_ctrl[CTL_INT];
                        end
                    end else begin
                        n_slow_phase = r_slow_phase + 16'd1;
                    end
                end else begin
                    n_instr_phase = r_instr_phase + 10'd1;
                end
            end
            CMD_WR_SLOW:    n_slow_counter = i_data[SLOW_W-1:0];
            CMD_WR_SLOW_CT: n_slow_ctrl    = i_data[CTRL_W-1:0];
            CMD_WR_FAST:    n_fast_counter = i_data[FAST_COUNT_WIDTH-1:0];
            CMD_WR_FAST_CT: n_fast_ctrl    = i_data[CTRL_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_instr_phase  <= '0;
            r_slow_phase   <= '0;
            r_slow_counter <= '0;
            r_fast_counter <= '0;
            r_slow_ctrl    <= '0;
            r_fast_ctrl    <= '0;
        end else if (i_fire) begin
            r_instr_phase  <= n_instr_phase;
            r_slow_phase   <= n_slow_phase;
            r_slow_counter <= n_slow_counter;
            r_fast_counter <= n_fast_counter;
            r_slow_ctrl    <= n_slow_ctrl;
            r_fast_ctrl    <= n_fast_ctrl;
        end
    end

    assign o_result.wake       = wake;
    assign o_result.irq        = irq;
    assign o_result.slow_value = n_slow_counter;
    assign o_result.slow_ctrl  = n_slow_ctrl;
    assign o_result.fast_ctrl  = n_fast_ctrl;
    assign o_fast_value        = n_fast_counter;

    // Only a control write may drop a service request.
    a_fast_sreq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_fire && i_cmd == CMD_WR_FAST_CT) |=> !$fell(r_fast_ctrl[CTL_SREQ]))
        else $error("fast service request cleared without a control write");

    a_slow_sreq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_fire && i_cmd == CMD_WR_SLOW_CT) |=> !$fell(r_slow_ctrl[CTL_SREQ]))
        else $error("slow service request cleared without a control write");

    // A pulse always comes with a service request in the same result.
    a_pulse_sreq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.wake || o_result.irq) |->
            (o_result.fast_ctrl[CTL_SREQ] || o_result.slow_ctrl[CTL_SREQ]))
        else $error("pulse without a service request");

    // A retire request without a fast tick leaves the counters unchanged.
    a_no_tick_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cmd == CMD_RETIRE && !fast_tick) |=>
            ($stable(r_fast_counter) && $stable(r_slow_counter)))
        else $error("counter moved without a fast tick");

endmodule
